// ===== design/jte_pkg.sv =====
// ----------------------------------------------------------------------------
// jte_pkg
// Shared types and constants for the job table engine: command and response
// words, the scan token that walks the cell chain, and the commit broadcast.
// ----------------------------------------------------------------------------
package jte_pkg;

    localparam int JTE_ENTRIES = 16;

    localparam int KEY_W    = 22;
    localparam int NUM_W    = 16;
    localparam int STATUS_W = 2;

    localparam logic [NUM_W-1:0]    NUM_TOP     = {NUM_W{1'b1}};
    localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd2;

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_DEL      = 2'd1,
        OP_FIND_KEY = 2'd2,
        OP_FIND_NUM = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CODE_OK   = 2'd0,
        CODE_MISS = 2'd1,
        CODE_FULL = 2'd2
    } code_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_FINISH = 2'd2
    } state_t;

    typedef struct packed {
        op_t                 op;
        logic [KEY_W-1:0]    proc_key;
        logic [NUM_W-1:0]    job_num;
        logic [STATUS_W-1:0] new_status;
    } cmd_t;

    typedef struct packed {
        code_t               code;
        logic [KEY_W-1:0]    out_key;
        logic [NUM_W-1:0]    out_num;
        logic [STATUS_W-1:0] out_status;
    } rsp_t;

    // Token passed from cell to cell, one cell per cycle
    typedef struct packed {
        logic                valid;
        op_t                 op;
        logic [KEY_W-1:0]    key;
        logic [NUM_W-1:0]    num;
        logic                found;
        logic                free_seen;
        logic [NUM_W-1:0]    top_num;
        logic [KEY_W-1:0]    res_key;
        logic [NUM_W-1:0]    res_num;
        logic [STATUS_W-1:0] res_status;
    } token_t;

    // Broadcast to every cell once the token has left the chain
    typedef struct packed {
        logic                done;
        logic                add;
        logic                del;
        logic [KEY_W-1:0]    key;
        logic [NUM_W-1:0]    num;
        logic [STATUS_W-1:0] status;
    } commit_t;

endpackage

// ===== design/jte_cell.sv =====
// ----------------------------------------------------------------------------
// jte_cell
// One table entry. Compares the passing token against its entry, marks itself
// as the target of a pending add or delete, and applies the commit.
// ----------------------------------------------------------------------------
module jte_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  jte_pkg::token_t  tok_in,
    output jte_pkg::token_t  tok_out,
    input  jte_pkg::commit_t commit
);

    logic [jte_pkg::KEY_W-1:0]    key_reg,  key_next;
    logic [jte_pkg::NUM_W-1:0]    num_reg,  num_next;
    logic [jte_pkg::STATUS_W-1:0] stat_reg, stat_next;
    logic                         hit_reg,  hit_next;
    logic                         free_reg, free_next;
    jte_pkg::token_t              tok_reg,  tok_next;

    logic used;
    logic match;
    logic take_hit;
    logic take_free;

    assign used = (key_reg != '0);

    always_comb
    begin
        case (tok_in.op)
            jte_pkg::OP_DEL,
            jte_pkg::OP_FIND_KEY: match = used && (key_reg == tok_in.key);
            jte_pkg::OP_FIND_NUM: match = used && (num_reg == tok_in.num);
            default:              match = 1'b0;
        endcase
    end

    assign take_hit  = tok_in.valid && !tok_in.found && match;
    assign take_free = tok_in.valid && (tok_in.op == jte_pkg::OP_ADD) &&
                       (tok_in.key != '0) && !tok_in.free_seen && !used;

    always_comb
    begin
        tok_next = tok_in;
        if (take_hit)
        begin
            tok_next.found      = 1'b1;
            tok_next.res_key    = key_reg;
            tok_next.res_num    = num_reg;
            tok_next.res_status = stat_reg;
        end
        if (take_free)
        begin
            tok_next.free_seen = 1'b1;
        end
        if (used && (num_reg > tok_in.top_num))
        begin
            tok_next.top_num = num_reg;
        end
    end

    // Entry and target flags
    always_comb
    begin
        key_next  = key_reg;
        num_next  = num_reg;
        stat_next = stat_reg;
        hit_next  = hit_reg;
        free_next = free_reg;
        if (commit.done)
        begin
            hit_next  = 1'b0;
            free_next = 1'b0;
            if (commit.add && free_reg)
            begin
                key_next  = commit.key;
                num_next  = commit.num;
                stat_next = commit.status;
            end
            if (commit.del && hit_reg)
            begin
                key_next  = '0;
                num_next  = '0;
                stat_next = jte_pkg::STATUS_DONE;
            end
        end
        else
        begin
            if (take_hit && (tok_in.op == jte_pkg::OP_DEL))
            begin
                hit_next = 1'b1;
            end
            if (take_free)
            begin
                free_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg  <= '0;
            num_reg  <= '0;
            stat_reg <= jte_pkg::STATUS_DONE;
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
            tok_reg  <= '0;
        end
        else
        begin
            key_reg  <= key_next;
            num_reg  <= num_next;
            stat_reg <= stat_next;
            hit_reg  <= hit_next;
            free_reg <= free_next;
            tok_reg  <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== design/job_table_engine.sv =====
// ----------------------------------------------------------------------------
// job_table_engine
// Job table with key lookup, number lookup, delete and lowest-free add.
// ----------------------------------------------------------------------------
// Each table entry lives in its own cell, and a command word walks the row of
// ENTRIES cells one cell per clock, collecting the first match, the lowest
// free entry and the largest job number in use. When it leaves the last cell
// it is held in end_reg; once the output register is free or being read, the
// response is formed and the chosen cell is written or cleared in the same
// cycle. A new command is taken only once the engine is idle again after that.
// A response waiting in the output register does not stop the next command
// being taken and scanned, but it cannot finish until that response is taken.
module job_table_engine #(
    parameter int ENTRIES = jte_pkg::JTE_ENTRIES
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  jte_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output jte_pkg::rsp_t rsp
);

    jte_pkg::state_t  state_reg, state_next;
    jte_pkg::token_t  head;
    jte_pkg::token_t  chain [ENTRIES+1];
    jte_pkg::token_t  end_reg, end_next;
    jte_pkg::commit_t commit;
    jte_pkg::rsp_t    result;
    jte_pkg::rsp_t    rsp_reg, rsp_next;
    logic             rsp_valid_reg, rsp_valid_next;

    logic                      accept;
    logic                      latch_end;
    logic                      finish;
    logic [jte_pkg::NUM_W-1:0] new_num;

    assign accept = cmd_valid && !cmd_stall;

    // Inject the command at the head of the chain
    always_comb
    begin
        head            = '0;
        head.valid      = accept;
        head.op         = cmd.op;
        head.key        = cmd.proc_key;
        head.num        = cmd.job_num;
        head.res_status = cmd.new_status;
    end

    assign chain[0] = head;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        jte_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1]),
            .commit  (commit)
        );
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            jte_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = jte_pkg::ST_SCAN;
                end
            end
            jte_pkg::ST_SCAN:
            begin
                if (chain[ENTRIES].valid)
                begin
                    state_next = jte_pkg::ST_FINISH;
                end
            end
            jte_pkg::ST_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    state_next = jte_pkg::ST_IDLE;
                end
            end
            default: state_next = jte_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the controller
    always_comb
    begin
        cmd_stall = 1'b1;
        latch_end = 1'b0;
        finish    = 1'b0;
        case (state_reg)
            jte_pkg::ST_IDLE:   cmd_stall = 1'b0;
            jte_pkg::ST_SCAN:   latch_end = chain[ENTRIES].valid;
            jte_pkg::ST_FINISH: finish    = !rsp_valid_reg || !rsp_stall;
            default:            cmd_stall = 1'b1;
        endcase
    end

    // The add carries its status in res_status until a cell overwrites it;
    // an add never matches, so it arrives at the tail unchanged.
    assign new_num = (end_reg.top_num == jte_pkg::NUM_TOP) ? jte_pkg::NUM_TOP :
                     end_reg.top_num + 1'b1;

    always_comb
    begin
        result = '0;
        result.code = jte_pkg::CODE_MISS;
        if (end_reg.op == jte_pkg::OP_ADD)
        begin
            if (end_reg.free_seen)
            begin
                result.code       = jte_pkg::CODE_OK;
                result.out_key    = end_reg.key;
                result.out_num    = new_num;
                result.out_status = end_reg.res_status;
            end
            else if (end_reg.key != '0)
            begin
                result.code = jte_pkg::CODE_FULL;
            end
        end
        else if (end_reg.found)
        begin
            result.code       = jte_pkg::CODE_OK;
            result.out_key    = end_reg.res_key;
            result.out_num    = end_reg.res_num;
            result.out_status = end_reg.res_status;
        end
    end

    always_comb
    begin
        commit.done   = finish;
        commit.add    = finish && (end_reg.op == jte_pkg::OP_ADD) && end_reg.free_seen;
        commit.del    = finish && (end_reg.op == jte_pkg::OP_DEL) && end_reg.found;
        commit.key    = end_reg.key;
        commit.num    = new_num;
        commit.status = end_reg.res_status;
    end

    always_comb
    begin
        end_next       = latch_end ? chain[ENTRIES] : end_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (finish)
        begin
            rsp_next       = result;
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= jte_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        end_reg <= end_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chain[ENTRIES].valid |-> state_reg == jte_pkg::ST_SCAN)
        else $error("token left the chain outside a scan");

    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == jte_pkg::ST_SCAN)
        else $error("accepted word did not start a scan");

    a_commit_one: assert property (@(posedge clk) disable iff (!rst_n)
        !(commit.add && commit.del))
        else $error("add and delete committed together");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        finish |-> (!rsp_valid_reg || !rsp_stall))
        else $error("response overwritten while stalled");

endmodule

// ===== tb/job_table_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// job_table_checker
// Watches the command and response channels of the job table engine. It keeps
// its own copy of the table, works out the response to every accepted command
// word and compares each accepted response word, field by field, with the
// oldest one still waiting.
// ----------------------------------------------------------------------------
module job_table_checker
    import jte_pkg::*;
#(
    parameter int ENTRIES = JTE_ENTRIES
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  logic cmd_stall,
    input  cmd_t cmd,
    input  logic rsp_valid,
    input  logic rsp_stall,
    input  rsp_t rsp,
    output int   mismatches,
    output int   outstanding
);

    localparam int REPORT_CAP = 100;

    logic [KEY_W-1:0]    shadow_key  [ENTRIES];
    logic [NUM_W-1:0]    shadow_num  [ENTRIES];
    logic [STATUS_W-1:0] shadow_stat [ENTRIES];

    rsp_t pending_rsp [$];
    rsp_t oldest_rsp;
    int   rsp_seen = 0;
    int   mismatch_total = 0;

    assign mismatches = mismatch_total;

    function automatic rsp_t entry_rsp(input int slot);
        rsp_t r;
        r.code       = CODE_OK;
        r.out_key    = shadow_key[slot];
        r.out_num    = shadow_num[slot];
        r.out_status = shadow_stat[slot];
        return r;
    endfunction

    // Apply one command to the table copy and return the response it yields
    function automatic rsp_t apply_job_cmd(input cmd_t c);
        rsp_t             r;
        int               hit;
        logic [NUM_W-1:0] peak;
        r      = '0;
        r.code = CODE_MISS;
        hit    = -1;
        peak   = '0;
        case (c.op)
            OP_ADD:
            begin
                if (c.proc_key != '0)
                begin
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (hit < 0 && shadow_key[i] == '0)
                            hit = i;
                        if (shadow_key[i] != '0 && shadow_num[i] > peak)
                            peak = shadow_num[i];
                    end
                    if (hit < 0)
                        r.code = CODE_FULL;
                    else
                    begin
                        shadow_key[hit]  = c.proc_key;
                        shadow_stat[hit] = c.new_status;
                        shadow_num[hit]  = (peak == NUM_TOP) ? NUM_TOP : peak + 1'b1;
                        r = entry_rsp(hit);
                    end
                end
            end
            OP_DEL, OP_FIND_KEY:
            begin
                // a free entry holds key zero, so a zero key must never match
                if (c.proc_key != '0)
                    for (int i = 0; i < ENTRIES; i++)
                        if (hit < 0 && shadow_key[i] == c.proc_key)
                            hit = i;
                if (hit >= 0)
                begin
                    r = entry_rsp(hit);
                    if (c.op == OP_DEL)
                    begin
                        shadow_key[hit]  = '0;
                        shadow_num[hit]  = '0;
                        shadow_stat[hit] = STATUS_DONE;
                    end
                end
            end
            default:
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (hit < 0 && shadow_key[i] != '0 && shadow_num[i] == c.job_num)
                        hit = i;
                if (hit >= 0)
                    r = entry_rsp(hit);
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_total < REPORT_CAP)
            $display("%0t: response %0d: %s is %0h, expected %0h",
                     $time, rsp_seen, what, got, want);
        mismatch_total++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                shadow_key[i]  = '0;
                shadow_num[i]  = '0;
                shadow_stat[i] = STATUS_DONE;
            end
            pending_rsp.delete();
            outstanding <= 0;
        end
        else
        begin
            // take the response first: a word accepted now cannot answer itself
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_rsp.size() == 0)
                    report_mismatch("code of a word with nothing waiting",
                                    32'(rsp.code), '0);
                else
                begin
                    oldest_rsp = pending_rsp.pop_front();
                    if (rsp.code !== oldest_rsp.code)
                        report_mismatch("code", 32'(rsp.code), 32'(oldest_rsp.code));
                    if (rsp.out_key !== oldest_rsp.out_key)
                        report_mismatch("out_key", 32'(rsp.out_key),
                                        32'(oldest_rsp.out_key));
                    if (rsp.out_num !== oldest_rsp.out_num)
                        report_mismatch("out_num", 32'(rsp.out_num),
                                        32'(oldest_rsp.out_num));
                    if (rsp.out_status !== oldest_rsp.out_status)
                        report_mismatch("out_status", 32'(rsp.out_status),
                                        32'(oldest_rsp.out_status));
                end
                rsp_seen++;
            end
            if (cmd_valid && !cmd_stall)
                pending_rsp.push_back(apply_job_cmd(cmd));
            outstanding <= pending_rsp.size();
        end
    end

endmodule

// ===== tb/tb_job_table_engine.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_job_table_engine
// Drives command words into the job table engine and takes its responses
// with random gaps and stalls. A directed opening walks the empty, duplicate,
// zero-key and full-table cases; random traffic follows, with a short climb of
// job numbers by alternating add and delete between two random halves. The
// checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_job_table_engine;

    import jte_pkg::*;

    localparam int CYCLE_LIMIT  = 6_000_000;
    localparam int DRAIN_CYCLES = 2 * JTE_ENTRIES + 8;
    localparam int RANDOM_WORDS = 600;
    localparam int BLOCK_WORDS  = 50;
    localparam int POOL_SIZE    = 32;
    localparam int CLIMB_STEPS  = 20;

    localparam logic [KEY_W-1:0] KEY_MAX     = '1;
    localparam logic [KEY_W-1:0] KEY_REUSE   = 22'h155555;
    localparam logic [KEY_W-1:0] CLIMB_KEY_A = 22'h0F0F0F;
    localparam logic [KEY_W-1:0] CLIMB_KEY_B = 22'h30F0F0;

    typedef enum int {
        IDLE_NONE,
        IDLE_BUSY,
        IDLE_SPARSE
    } idle_mode_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    cmd_t cmd;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    int         fail_count;
    int         in_flight;
    int         cycle_count;
    idle_mode_t idle_mode;
    int         num_hint;
    int         key_copies [logic [KEY_W-1:0]];
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    job_table_engine #(
        .ENTRIES (JTE_ENTRIES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    job_table_checker #(
        .ENTRIES (JTE_ENTRIES)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .mismatches  (fail_count),
        .outstanding (in_flight)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int draw_wait();
        case (idle_mode)
            IDLE_NONE: return 0;
            IDLE_BUSY: return $urandom_range(0, 18);
            default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
        endcase
    endfunction

    function automatic cmd_t job_word(input op_t o, input logic [KEY_W-1:0] k,
                                      input logic [NUM_W-1:0] n,
                                      input logic [STATUS_W-1:0] s);
        cmd_t w;
        w.op         = o;
        w.proc_key   = k;
        w.job_num    = n;
        w.new_status = s;
        return w;
    endfunction

    // Mostly pool keys so that finds and deletes hit; one word in eight is noise
    function automatic cmd_t random_word();
        cmd_t w;
        int   pick;
        int   lo;
        w.op         = op_t'($urandom_range(0, 3));
        w.proc_key   = KEY_W'($urandom_range(0, 22'h3FFFFF));
        w.job_num    = NUM_W'($urandom_range(0, 16'hFFFF));
        w.new_status = STATUS_W'($urandom_range(0, 3));
        if ($urandom_range(0, 7) == 0)
        begin
            if ($urandom_range(0, 3) == 0)
                w.proc_key = '0;
            return w;
        end
        pick = $urandom_range(0, 99);
        if (pick < 30)
            w.op = OP_ADD;
        else if (pick < 60)
            w.op = OP_DEL;
        else if (pick < 80)
            w.op = OP_FIND_KEY;
        else
            w.op = OP_FIND_NUM;
        if ($urandom_range(0, 19) == 0)
            w.proc_key = '0;
        else if ($urandom_range(0, 3) != 0)
            w.proc_key = key_pool[$urandom_range(0, 11)];
        else
            w.proc_key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        // aim at recently issued numbers
        if (w.op == OP_FIND_NUM && $urandom_range(0, 7) != 0)
        begin
            lo = (num_hint > 40) ? num_hint - 40 : 0;
            w.job_num = NUM_W'($urandom_range(lo, num_hint + 2));
        end
        return w;
    endfunction

    // Hold the word until taken; track an upper bound of the copies of each key
    task automatic send_word(input cmd_t w);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd       <= w;
        cmd_valid <= 1'b1;
        do @(posedge clk); while (cmd_stall);
        if (w.proc_key != '0)
        begin
            if (w.op == OP_ADD)
            begin
                if (!key_copies.exists(w.proc_key))
                    key_copies[w.proc_key] = 0;
                if (key_copies[w.proc_key] < JTE_ENTRIES)
                    key_copies[w.proc_key]++;
                if (num_hint < NUM_TOP)
                    num_hint++;
            end
            else if (w.op == OP_DEL && key_copies.exists(w.proc_key))
            begin
                if (key_copies[w.proc_key] > 0)
                    key_copies[w.proc_key]--;
            end
        end
    endtask

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        do @(posedge clk); while (in_flight != 0);
    endtask

    // Delete every key as often as it may still be held
    task automatic clear_table();
        logic [KEY_W-1:0] held [$];
        foreach (key_copies[k])
            held.push_back(k);
        foreach (held[i])
            repeat (key_copies[held[i]])
                send_word(job_word(OP_DEL, held[i],
                                   NUM_W'($urandom_range(0, 16'hFFFF)),
                                   STATUS_W'($urandom_range(0, 3))));
        key_copies.delete();
        num_hint = 0;
    endtask

    task automatic random_run(input int words);
        for (int n = 0; n < words; n++)
        begin
            if (n % BLOCK_WORDS == 0)
            begin
                if (n > 0 && $urandom_range(0, 3) == 0)
                    wait_drained();
                idle_mode = idle_mode_t'($urandom_range(0, 2));
            end
            send_word(random_word());
        end
    endtask

    // Response side: a fresh stall length for every word
    initial
    begin
        int stall_len;
        rsp_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall_len = draw_wait();
            if (stall_len > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do @(posedge clk); while (!rsp_valid);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        logic [KEY_W-1:0] cur_key;
        logic [KEY_W-1:0] next_key;
        logic [KEY_W-1:0] spare_key;
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        idle_mode = IDLE_BUSY;
        num_hint  = 0;
        key_pool[0] = KEY_MAX;
        key_pool[1] = 22'd1;
        for (int i = 2; i < POOL_SIZE; i++)
            do key_pool[i] = KEY_W'($urandom_range(2, 22'h3FFFFE));
            while (key_pool[i] == CLIMB_KEY_A || key_pool[i] == CLIMB_KEY_B);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // empty table
        send_word(job_word(OP_FIND_KEY, key_pool[2], 16'hFFFF, 2'd3));
        send_word(job_word(OP_FIND_NUM, KEY_MAX, 16'd0, 2'd0));
        send_word(job_word(OP_DEL, key_pool[2], 16'd0, 2'd3));
        send_word(job_word(OP_ADD, '0, 16'hFFFF, 2'd1));
        // extremes of key and status, then a duplicate key
        send_word(job_word(OP_ADD, KEY_MAX, 16'd0, 2'd3));
        send_word(job_word(OP_ADD, 22'd1, 16'hFFFF, 2'd0));
        send_word(job_word(OP_ADD, KEY_MAX, 16'd0, 2'd1));
        send_word(job_word(OP_FIND_KEY, KEY_MAX, 16'hFFFF, 2'd0));
        send_word(job_word(OP_FIND_NUM, '0, 16'd3, 2'd3));
        send_word(job_word(OP_FIND_NUM, KEY_MAX, 16'hFFFF, 2'd0));
        // the lowest copy goes first
        send_word(job_word(OP_DEL, KEY_MAX, 16'hFFFF, 2'd0));
        send_word(job_word(OP_DEL, '0, 16'd0, 2'd3));
        send_word(job_word(OP_FIND_KEY, '0, 16'd1, 2'd1));
        send_word(job_word(OP_ADD, KEY_REUSE, 16'd0, 2'd2));
        for (int i = 2; i < 15; i++)
            send_word(job_word(OP_ADD, key_pool[i], 16'd0,
                               STATUS_W'($urandom_range(0, 3))));
        send_word(job_word(OP_ADD, key_pool[15], 16'hFFFF, 2'd1));
        wait_drained();

        random_run(RANDOM_WORDS);
        wait_drained();
        idle_mode = IDLE_SPARSE;
        clear_table();

        // climb the job number: add one key, drop the older one
        idle_mode = IDLE_NONE;
        cur_key  = CLIMB_KEY_A;
        next_key = CLIMB_KEY_B;
        send_word(job_word(OP_ADD, cur_key, 16'd0, 2'd0));
        repeat (CLIMB_STEPS)
        begin
            send_word(job_word(OP_ADD, next_key, NUM_W'($urandom_range(0, 16'hFFFF)),
                               STATUS_W'($urandom_range(0, 3))));
            send_word(job_word(OP_DEL, cur_key, 16'd0, 2'd0));
            spare_key = cur_key;
            cur_key   = next_key;
            next_key  = spare_key;
        end
        idle_mode = IDLE_BUSY;
        send_word(job_word(OP_ADD, key_pool[2], 16'd0, 2'd1));
        send_word(job_word(OP_ADD, key_pool[3], 16'd0, 2'd3));
        send_word(job_word(OP_FIND_NUM, '0, NUM_TOP, 2'd0));
        send_word(job_word(OP_DEL, cur_key, 16'd0, 2'd0));
        send_word(job_word(OP_FIND_NUM, '0, NUM_TOP, 2'd0));
        wait_drained();
        clear_table();

        random_run(RANDOM_WORDS);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/jte_pkg.sv
design/jte_cell.sv
design/job_table_engine.sv
tb/job_table_checker.sv
tb/tb_job_table_engine.sv
